// ===== hdl/ymdt_pkg.sv =====
package ymdt_pkg;

    localparam int LENGTH_W = 8;
    localparam int CHAR_W   = 8;
    localparam int NUM_CHARS = 10;
    localparam int DAY_W    = 23;
    localparam int STATUS_W = 3;

    localparam int YEAR_W   = 14;
    localparam int TWO_DIGIT_W = 7;
    localparam int YY_W     = YEAR_W + 1;
    localparam int ERA_W    = 6;
    localparam int DOY_W    = 9;
    localparam int YOE_W    = 9;
    localparam int DOE_W    = 18;
    localparam int SUM_W    = 25;

    localparam logic [LENGTH_W-1:0] DATE_LENGTH = 8'd10;
    localparam logic [CHAR_W-1:0]   CHAR_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0]   CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]   CHAR_NINE   = 8'h39;

    localparam int EPOCH_SHIFT   = 719468;
    localparam int ERA_DAYS      = 146097;
    localparam int ERA_YEARS     = 400;
    localparam int DAYS_PER_YEAR = 365;

    // floor(x / 400) for x < 10000 as (x * 5243) >> 21
    localparam int ERA_RECIP       = 5243;
    localparam int ERA_RECIP_SHIFT = 21;
    localparam int ERA_PROD_W      = 27;
    // floor(x / 100) for x < 400 as (x * 41) >> 12
    localparam int CENT_RECIP       = 41;
    localparam int CENT_RECIP_SHIFT = 12;
    localparam int CENT_PROD_W      = 15;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_LENGTH    = 3'd1,
        ST_SEPARATOR = 3'd2,
        ST_DIGIT     = 3'd3,
        ST_MONTH     = 3'd4,
        ST_DAY       = 3'd5
    } status_t;

    typedef struct packed {
        status_t                 status;
        logic [YEAR_W-1:0]       year;
        logic [TWO_DIGIT_W-1:0]  month;
        logic [TWO_DIGIT_W-1:0]  day;
        logic                    leap;
    } parse_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // day of a march-based year on which the month starts
    function automatic logic [DOY_W-1:0] month_start(input logic [3:0] month);
        logic [DOY_W-1:0] start;
        case (month)
            4'd3:    start = 9'd0;
            4'd4:    start = 9'd31;
            4'd5:    start = 9'd61;
            4'd6:    start = 9'd92;
            4'd7:    start = 9'd122;
            4'd8:    start = 9'd153;
            4'd9:    start = 9'd184;
            4'd10:   start = 9'd214;
            4'd11:   start = 9'd245;
            4'd12:   start = 9'd275;
            4'd1:    start = 9'd306;
            4'd2:    start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

// ===== hdl/ymdt_in_if.sv =====
interface ymdt_in_if;
    import ymdt_pkg::*;

    logic                valid;
    logic                ready;
    logic [LENGTH_W-1:0] text_length;
    logic [CHAR_W-1:0]   char_0;
    logic [CHAR_W-1:0]   char_1;
    logic [CHAR_W-1:0]   char_2;
    logic [CHAR_W-1:0]   char_3;
    logic [CHAR_W-1:0]   char_4;
    logic [CHAR_W-1:0]   char_5;
    logic [CHAR_W-1:0]   char_6;
    logic [CHAR_W-1:0]   char_7;
    logic [CHAR_W-1:0]   char_8;
    logic [CHAR_W-1:0]   char_9;

    modport source (
        output valid, text_length, char_0, char_1, char_2, char_3, char_4,
               char_5, char_6, char_7, char_8, char_9,
        input  ready
    );

    modport sink (
        input  valid, text_length, char_0, char_1, char_2, char_3, char_4,
               char_5, char_6, char_7, char_8, char_9,
        output ready
    );
endinterface

// ===== hdl/ymdt_out_if.sv =====
interface ymdt_out_if;
    import ymdt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [DAY_W-1:0] day_number;
    logic [STATUS_W-1:0]     status;

    modport source (
        output valid, day_number, status,
        input  ready
    );

    modport sink (
        input  valid, day_number, status,
        output ready
    );
endinterface

// ===== hdl/ymdt_parse.sv =====
module ymdt_parse (
    input  logic [ymdt_pkg::LENGTH_W-1:0]                       text_length,
    input  logic [ymdt_pkg::NUM_CHARS-1:0][ymdt_pkg::CHAR_W-1:0] chars,
    output ymdt_pkg::parse_t                                    parsed
);
    import ymdt_pkg::*;

    // positions that must hold digits
    localparam logic [NUM_CHARS-1:0] DIGIT_POS = 10'b11_0110_1111;

    logic [NUM_CHARS-1:0]      is_digit;
    logic [NUM_CHARS-1:0][3:0] dig;
    logic                      sep_ok;
    logic                      digits_ok;
    logic [4:0]                lo_mod;
    logic [4:0]                hi_mod;
    logic                      lo_zero;

    always_comb
    begin
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            is_digit[i] = (chars[i] >= CHAR_ZERO) && (chars[i] <= CHAR_NINE);
            dig[i]      = chars[i][3:0];
        end
    end

    assign sep_ok    = (chars[4] == CHAR_DASH) && (chars[7] == CHAR_DASH);
    assign digits_ok = &(is_digit | ~DIGIT_POS);

    // divisibility by 4 of a two-digit number ab: 2a + b mod 4
    assign lo_mod  = {dig[2], 1'b0} + {1'b0, dig[3]};
    assign hi_mod  = {dig[0], 1'b0} + {1'b0, dig[1]};
    assign lo_zero = (dig[2] == 4'd0) && (dig[3] == 4'd0);

    always_comb
    begin
        if (text_length != DATE_LENGTH)
            parsed.status = ST_LENGTH;
        else if (!sep_ok)
            parsed.status = ST_SEPARATOR;
        else if (!digits_ok)
            parsed.status = ST_DIGIT;
        else
            parsed.status = ST_OK;

        parsed.year  = YEAR_W'(dig[0]) * YEAR_W'(1000) + YEAR_W'(dig[1]) * YEAR_W'(100)
                     + YEAR_W'(dig[2]) * YEAR_W'(10) + YEAR_W'(dig[3]);
        parsed.month = TWO_DIGIT_W'(dig[5]) * TWO_DIGIT_W'(10) + TWO_DIGIT_W'(dig[6]);
        parsed.day   = TWO_DIGIT_W'(dig[8]) * TWO_DIGIT_W'(10) + TWO_DIGIT_W'(dig[9]);
        parsed.leap  = lo_zero ? (hi_mod[1:0] == 2'd0) : (lo_mod[1:0] == 2'd0);
    end
endmodule

// ===== hdl/ymd_text_to_day_number_core.sv =====
// date text to day number converter
//
// text channel: one beat carries a "YYYY-MM-DD" string as ten character
// bytes plus its length. result channel: one beat per text beat, in order,
// with the day count since 1970-01-01 and a status (ok, bad length, bad
// separator, non-digit, bad month, bad day); day_number is zero unless ok.
//
// five register stages: parse and digit check, calendar check and era
// split, year-of-era, day-of-era, final sum into the output register.
// result valid is driven by the stage 5 output register;
// throughput is one beat per cycle, limited only by the result side.
//
// each stage carries a valid bit and loads when it is empty or when the
// stage after it moves, so a stalled result holds the pipe in place
// without dropping or repeating beats; text.ready falls only once all
// five stages are full and result.ready is low.
// reset (rst_n low) clears all valid bits; payload registers are not reset.
module ymd_text_to_day_number_core (
    input  logic              clk,
    input  logic              rst_n,
    ymdt_in_if.sink           text,
    ymdt_out_if.source        result
);
    import ymdt_pkg::*;

    // stage load enables, back to front
    logic en1, en2, en3, en4, en5;

    // stage 1: parse
    logic [NUM_CHARS-1:0][CHAR_W-1:0] chars;
    parse_t s1_next;
    parse_t s1_reg;
    logic   s1_valid_reg;

    // stage 2: calendar check, era
    status_t                  s2_status_next, s2_status_reg;
    logic signed [YY_W-1:0]   s2_yy_next, s2_yy_reg;
    logic signed [ERA_W-1:0]  s2_era_next, s2_era_reg;
    logic [DOY_W-1:0]         s2_doy_next, s2_doy_reg;
    logic                     s2_valid_reg;
    logic                     month_bad;
    logic                     day_bad;
    logic                     year_back;
    logic [4:0]               month_len;
    logic [ERA_PROD_W-1:0]    era_prod;

    // stage 3: year of era
    logic [YOE_W-1:0]         s3_yoe_next, s3_yoe_reg;
    logic signed [ERA_W-1:0]  s3_era_reg;
    logic [DOY_W-1:0]         s3_doy_reg;
    status_t                  s3_status_reg;
    logic                     s3_valid_reg;

    // stage 4: day of era
    logic [DOE_W-1:0]         s4_doe_next, s4_doe_reg;
    logic [CENT_PROD_W-1:0]   cent_prod;
    logic signed [ERA_W-1:0]  s4_era_reg;
    status_t                  s4_status_reg;
    logic                     s4_valid_reg;

    // stage 5: output register
    logic signed [SUM_W-1:0]  days_sum;
    logic signed [DAY_W-1:0]  s5_days_next, s5_days_reg;
    status_t                  s5_status_reg;
    logic                     s5_valid_reg;

    // handshake chain
    assign en5 = !s5_valid_reg || result.ready;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign text.ready        = en1;
    assign result.valid      = s5_valid_reg;
    assign result.day_number = s5_days_reg;
    assign result.status     = s5_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= text.valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
            if (en5) s5_valid_reg <= s4_valid_reg;
        end
    end

    // stage 1: length, separators, digits, field values
    assign chars = {text.char_9, text.char_8, text.char_7, text.char_6, text.char_5,
                    text.char_4, text.char_3, text.char_2, text.char_1, text.char_0};

    ymdt_parse u_parse (
        .text_length (text.text_length),
        .chars       (chars),
        .parsed      (s1_next)
    );

    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
    end

    // stage 2: month and day range, shift to a march-based year, era
    always_comb
    begin
        month_bad = (s1_reg.month == '0) || (s1_reg.month > TWO_DIGIT_W'(12));
        month_len = month_days(s1_reg.month[3:0], s1_reg.leap);
        day_bad   = (s1_reg.day == '0) || (s1_reg.day > TWO_DIGIT_W'(month_len));

        if (s1_reg.status != ST_OK)
            s2_status_next = s1_reg.status;
        else if (month_bad)
            s2_status_next = ST_MONTH;
        else if (day_bad)
            s2_status_next = ST_DAY;
        else
            s2_status_next = ST_OK;

        // january and february belong to the previous march-based year
        year_back  = s1_reg.month <= TWO_DIGIT_W'(2);
        s2_yy_next = $signed({1'b0, s1_reg.year} - {{YEAR_W{1'b0}}, year_back});

        era_prod    = ERA_PROD_W'(s2_yy_next[YEAR_W-1:0]) * ERA_PROD_W'(ERA_RECIP);
        s2_era_next = s2_yy_next[YY_W-1] ? '1
                                         : $signed(era_prod[ERA_RECIP_SHIFT +: ERA_W]);

        s2_doy_next = month_start(s1_reg.month[3:0]) + DOY_W'(s1_reg.day) - DOY_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_status_reg <= s2_status_next;
            s2_yy_reg     <= s2_yy_next;
            s2_era_reg    <= s2_era_next;
            s2_doy_reg    <= s2_doy_next;
        end
    end

    // stage 3: year within the 400-year era
    assign s3_yoe_next = YOE_W'(s2_yy_reg - YY_W'(s2_era_reg) * YY_W'(ERA_YEARS));

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_yoe_reg    <= s3_yoe_next;
            s3_era_reg    <= s2_era_reg;
            s3_doy_reg    <= s2_doy_reg;
            s3_status_reg <= s2_status_reg;
        end
    end

    // stage 4: day within the era
    assign cent_prod   = CENT_PROD_W'(s3_yoe_reg) * CENT_PROD_W'(CENT_RECIP);
    assign s4_doe_next = DOE_W'(s3_yoe_reg) * DOE_W'(DAYS_PER_YEAR)
                       + DOE_W'(s3_yoe_reg >> 2)
                       - DOE_W'(cent_prod >> CENT_RECIP_SHIFT)
                       + DOE_W'(s3_doy_reg);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_doe_reg    <= s4_doe_next;
            s4_era_reg    <= s3_era_reg;
            s4_status_reg <= s3_status_reg;
        end
    end

    // stage 5: rebase to 1970-01-01, zero on any rejection
    assign days_sum     = SUM_W'(s4_era_reg) * SUM_W'(ERA_DAYS)
                        + $signed({{(SUM_W-DOE_W){1'b0}}, s4_doe_reg})
                        - SUM_W'(EPOCH_SHIFT);
    assign s5_days_next = (s4_status_reg == ST_OK) ? days_sum[DAY_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_days_reg   <= s5_days_next;
            s5_status_reg <= s4_status_reg;
        end
    end
endmodule
